/* rtl/core/swb_pkg.sv */
package swb_pkg;

    localparam int NumTimers = 16;
    localparam int SelW      = (NumTimers > 1) ? $clog2(NumTimers) : 1;
    localparam int TimeW     = 32;
    localparam int KindW     = 3;
    localparam int IndexW    = 4;

    typedef enum logic [KindW-1:0] {
        KIND_TICK      = 3'd0,
        KIND_START     = 3'd1,
        KIND_STOP      = 3'd2,
        KIND_RESET     = 3'd3,
        KIND_READ      = 3'd4,
        KIND_START_ALL = 3'd5,
        KIND_STOP_ALL  = 3'd6,
        KIND_RESET_ALL = 3'd7
    } t_kind;

    typedef logic [TimeW-1:0] t_time;
    typedef logic [SelW-1:0]  t_sel;

    function automatic t_time sat_add(input t_time a, input t_time b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? {TimeW{1'b1}} : s[TimeW-1:0];
    endfunction

endpackage

/* rtl/core/stopwatch_bank_core.sv */
// Channel | Beat signals             | Payload
// --------+--------------------------+-------------------------------
// in      | i_in_valid / o_in_ready  | i_kind, i_timer_index
// out     | o_out_valid / i_out_ready| o_time_value, o_index_valid
//
// One item per cycle sustained while i_out_ready holds; each item goes from accept to result
// through the input register, then one pass through the timer lanes into the result register.
// All stopwatch lanes update in parallel, so the all-kinds cost no more than the single-timer kinds.
// Synchronous active-low reset clears the time counter, all stamps, totals and flags.
// A stalled result holds the pipe; the input register still takes a beat when empty.
module stopwatch_bank_core (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    output logic                      o_in_ready,
    input  logic [swb_pkg::KindW-1:0] i_kind,
    input  logic [swb_pkg::IndexW-1:0] i_timer_index,
    output logic                      o_out_valid,
    input  logic                      i_out_ready,
    output logic [swb_pkg::TimeW-1:0] o_time_value,
    output logic                      o_index_valid
);
    import swb_pkg::*;

    logic                r_s1_valid;
    t_kind               r_kind;
    logic [IndexW-1:0]   r_idx;

    t_time               r_now;
    t_time               r_stamp [NumTimers];
    t_time               r_total [NumTimers];
    logic [NumTimers-1:0] r_run;

    t_time               n_now;
    t_time               n_stamp [NumTimers];
    t_time               n_total [NumTimers];
    logic [NumTimers-1:0] n_run;

    logic                r_out_valid;
    t_time               r_time_value;
    logic                r_index_valid;
    t_time               n_time_value;
    logic                n_index_valid;

    logic                adv;
    logic                work;
    logic                user_ok;
    t_sel                sel;
    t_time               span [NumTimers];
    t_time               sum  [NumTimers];

    assign adv        = !r_out_valid || i_out_ready;
    assign work       = r_s1_valid && adv;
    assign o_in_ready = !r_s1_valid || adv;

    assign user_ok = (r_idx != '0) && (int'(r_idx) < NumTimers);
    assign sel     = t_sel'(r_idx);

    always_comb begin
        for (int i = 0; i < NumTimers; i++) begin
            span[i] = r_now - r_stamp[i];
            sum[i]  = sat_add(r_total[i], span[i]);
        end
    end

    always_comb begin
        n_now         = r_now;
        n_run         = r_run;
        n_time_value  = '0;
        n_index_valid = 1'b0;
        for (int i = 0; i < NumTimers; i++) begin
            n_stamp[i] = r_stamp[i];
            n_total[i] = r_total[i];
        end
        unique case (r_kind)
            KIND_TICK: begin
                n_now = r_now + t_time'(1);
            end
            KIND_START, KIND_STOP, KIND_RESET: begin
                n_index_valid = user_ok;
                for (int i = 1; i < NumTimers; i++) begin
                    if (user_ok && sel == t_sel'(i)) begin
                        if (r_kind == KIND_START) begin
                            n_stamp[i] = r_now;
                            n_run[i]   = 1'b1;
                        end else if (r_kind == KIND_STOP) begin
                            if (r_run[i]) begin
                                n_time_value = span[i];
                                n_total[i]   = sum[i];
                                n_stamp[i]   = '0;
                                n_run[i]     = 1'b0;
                            end
                        end else begin
                            n_stamp[i] = '0;
                            n_total[i] = '0;
                            n_run[i]   = 1'b0;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (r_idx == '0) begin
                    n_time_value  = r_now;
                    n_index_valid = 1'b1;
                end else if (user_ok) begin
                    n_index_valid = 1'b1;
                    n_time_value  = r_run[sel] ? sum[sel] : r_total[sel];
                end
            end
            KIND_START_ALL: begin
                for (int i = 1; i < NumTimers; i++) begin
                    n_stamp[i] = r_now;
                    n_run[i]   = 1'b1;
                end
            end
            KIND_STOP_ALL: begin
                for (int i = 1; i < NumTimers; i++) begin
                    if (r_run[i]) begin
                        n_total[i] = sum[i];
                        n_stamp[i] = '0;
                        n_run[i]   = 1'b0;
                    end
                end
            end
            KIND_RESET_ALL: begin
                for (int i = 1; i < NumTimers; i++) begin
                    n_stamp[i] = '0;
                    n_total[i] = '0;
                    n_run[i]   = 1'b0;
                end
            end
            default: begin
                n_now = r_now;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_now       <= '0;
            r_run       <= '0;
            for (int i = 0; i < NumTimers; i++) begin
                r_stamp[i] <= '0;
                r_total[i] <= '0;
            end
        end else begin
            if (o_in_ready) begin
                r_s1_valid <= i_in_valid;
            end
            if (work) begin
                r_out_valid <= 1'b1;
                r_now       <= n_now;
                r_run       <= n_run;
                for (int i = 0; i < NumTimers; i++) begin
                    r_stamp[i] <= n_stamp[i];
                    r_total[i] <= n_total[i];
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_kind <= t_kind'(i_kind);
            r_idx  <= i_timer_index;
        end
        if (work) begin
            r_time_value  <= n_time_value;
            r_index_valid <= n_index_valid;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_time_value  = r_time_value;
    assign o_index_valid = r_index_valid;

`ifndef SYNTHESIS
    a_bad_index_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_index_valid) |-> (r_time_value == '0))
        else $error("result for unusable index carries a nonzero time");

    a_overall_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_run[0])
        else $error("overall timer marked running");

    a_now_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_now == $past(r_now) || r_now == $past(r_now) + 32'd1))
        else $error("time counter moved by more than one");

    a_tick_only: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (work && r_kind != KIND_TICK) |=> $stable(r_now))
        else $error("time counter moved on a non-tick beat");
`endif

endmodule

/* test/testbench.sv */
module testbench;
    import swb_pkg::*;

    localparam int CycleLimit = 400000;
    localparam int RandomBeats = 1000;

    typedef struct packed {
        t_kind             kind;
        logic [IndexW-1:0] idx;
        logic              fixed;
        t_time             value;
        logic              ok;
    } t_plan_row;

    typedef struct packed {
        t_time value;
        logic  ok;
    } t_watch_result;

    // directed rows: fixed=1 means the expected result is typed in here
    localparam int PlanRows = 25;
    t_plan_row plan [0:PlanRows-1] = '{
        '{KIND_READ,      4'd0,  1'b1, 32'd0, 1'b1},
        '{KIND_READ,      4'd15, 1'b1, 32'd0, 1'b1},
        '{KIND_TICK,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_TICK,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_READ,      4'd0,  1'b1, 32'd2, 1'b1},
        '{KIND_START,     4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_STOP,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_RESET,     4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_STOP,      4'd7,  1'b1, 32'd0, 1'b1},
        '{KIND_START,     4'd1,  1'b1, 32'd0, 1'b1},
        '{KIND_START,     4'd15, 1'b1, 32'd0, 1'b1},
        '{KIND_TICK,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_START,     4'd1,  1'b1, 32'd0, 1'b1},
        '{KIND_TICK,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_TICK,      4'd0,  1'b1, 32'd0, 1'b0},
        '{KIND_STOP,      4'd15, 1'b1, 32'd3, 1'b1},
        '{KIND_READ,      4'd1,  1'b0, 32'd0, 1'b0},
        '{KIND_START_ALL, 4'd9,  1'b1, 32'd0, 1'b0},
        '{KIND_TICK,      4'd15, 1'b1, 32'd0, 1'b0},
        '{KIND_STOP_ALL,  4'd3,  1'b1, 32'd0, 1'b0},
        '{KIND_READ,      4'd15, 1'b0, 32'd0, 1'b0},
        '{KIND_RESET,     4'd15, 1'b1, 32'd0, 1'b1},
        '{KIND_READ,      4'd15, 1'b1, 32'd0, 1'b1},
        '{KIND_RESET_ALL, 4'd15, 1'b1, 32'd0, 1'b0},
        '{KIND_READ,      4'd1,  1'b1, 32'd0, 1'b1}
    };

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic [KindW-1:0]  i_kind = '0;
    logic [IndexW-1:0] i_timer_index = '0;
    logic              i_out_ready = 1'b0;
    logic              o_in_ready;
    logic              o_out_valid;
    logic [TimeW-1:0]  o_time_value;
    logic              o_index_valid;

    stopwatch_bank_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_kind        (i_kind),
        .i_timer_index (i_timer_index),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_time_value  (o_time_value),
        .o_index_valid (o_index_valid)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    // bank model state
    t_time         bank_now;
    t_time         bank_stamp   [NumTimers];
    t_time         bank_total   [NumTimers];
    logic          bank_running [NumTimers];
    t_watch_result pending_q[$];

    int unsigned errors = 0;
    int unsigned beats_in = 0;
    int unsigned results_seen = 0;
    int unsigned spans_seen = 0;
    int unsigned cycles = 0;
    int unsigned stall_left = 0;
    bit          fast_in = 1'b0;
    bit          fast_out = 1'b1;

    function automatic t_time add_clamped(input t_time a, input t_time b);
        logic [TimeW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[TimeW] ? '1 : s[TimeW-1:0];
    endfunction

    task automatic clear_watch(input int w);
        bank_stamp[w]   = '0;
        bank_total[w]   = '0;
        bank_running[w] = 1'b0;
    endtask

    task automatic stop_watch(input int w, output t_time span);
        span = '0;
        if (bank_running[w]) begin
            span            = bank_now - bank_stamp[w];
            bank_total[w]   = add_clamped(bank_total[w], span);
            bank_running[w] = 1'b0;
            bank_stamp[w]   = '0;
        end
    endtask

    task automatic step_bank(input t_kind k, input logic [IndexW-1:0] ix,
                             output t_time val, output logic ok);
        bit    user_ix;
        t_time span;
        user_ix = (ix != 0) && (int'(ix) < NumTimers);
        val = '0;
        ok  = 1'b0;
        case (k)
            KIND_TICK: begin
                bank_now = bank_now + 1;
            end
            KIND_START: begin
                if (user_ix) begin
                    bank_stamp[ix]   = bank_now;
                    bank_running[ix] = 1'b1;
                    ok = 1'b1;
                end
            end
            KIND_STOP: begin
                if (user_ix) begin
                    stop_watch(ix, val);
                    ok = 1'b1;
                end
            end
            KIND_RESET: begin
                if (user_ix) begin
                    clear_watch(ix);
                    ok = 1'b1;
                end
            end
            KIND_READ: begin
                if (ix == 0) begin
                    val = bank_now;
                    ok  = 1'b1;
                end else if (user_ix) begin
                    val = bank_total[ix];
                    if (bank_running[ix]) begin
                        val = add_clamped(val, bank_now - bank_stamp[ix]);
                    end
                    ok = 1'b1;
                end
            end
            KIND_START_ALL: begin
                for (int w = 1; w < NumTimers; w++) begin
                    bank_stamp[w]   = bank_now;
                    bank_running[w] = 1'b1;
                end
            end
            KIND_STOP_ALL: begin
                for (int w = 1; w < NumTimers; w++) begin
                    stop_watch(w, span);
                end
            end
            default: begin
                for (int w = 1; w < NumTimers; w++) begin
                    clear_watch(w);
                end
            end
        endcase
    endtask

    // called at a rising edge; returns at the edge the beat is taken
    task automatic send_beat(input t_kind k, input logic [IndexW-1:0] ix,
                             input logic fixed, input t_time fval, input logic fok);
        int unsigned   gap;
        t_watch_result res;
        gap = fast_in ? 0 : $urandom_range(0, 14);
        if ($urandom_range(0, 63) == 0) fast_in = !fast_in;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_kind        <= k;
        i_timer_index <= ix;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        step_bank(k, ix, res.value, res.ok);
        if (fixed) begin
            res.value = fval;
            res.ok    = fok;
        end
        pending_q.push_back(res);
        beats_in++;
    endtask

    task automatic send_random(input t_kind k, input logic [IndexW-1:0] ix);
        send_beat(k, ix, 1'b0, '0, 1'b0);
    endtask

    function automatic t_kind pick_kind();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 35) return KIND_TICK;
        if (r < 50) return KIND_START;
        if (r < 65) return KIND_STOP;
        if (r < 70) return KIND_RESET;
        if (r < 88) return KIND_READ;
        if (r < 92) return KIND_START_ALL;
        if (r < 96) return KIND_STOP_ALL;
        return KIND_RESET_ALL;
    endfunction

    task automatic run_ticks(input int unsigned most);
        repeat ($urandom_range(0, most)) begin
            send_random(KIND_TICK, IndexW'($urandom_range(0, 15)));
        end
    endtask

    // start, ticks, read, ticks, stop, maybe read; at times bank-wide start/stop
    task automatic timing_run();
        logic [IndexW-1:0] w;
        bit                bank_wide;
        w = IndexW'($urandom_range(1, NumTimers - 1));
        bank_wide = ($urandom_range(0, 3) == 0);
        if (bank_wide) send_random(KIND_START_ALL, IndexW'($urandom_range(0, 15)));
        else send_random(KIND_START, w);
        run_ticks(8);
        send_random(KIND_READ, w);
        run_ticks(8);
        if (bank_wide) send_random(KIND_STOP_ALL, IndexW'($urandom_range(0, 15)));
        else send_random(KIND_STOP, w);
        if ($urandom_range(0, 1) == 0) send_random(KIND_READ, w);
    endtask

    // result side: random stalls after each beat, with stall-free stretches
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (pending_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result time_value=%h index_valid=%b",
                             $time, o_time_value, o_index_valid);
                end else begin
                    t_watch_result want;
                    want = pending_q.pop_front();
                    if (o_time_value !== want.value) begin
                        errors++;
                        $display("%0t: time_value expected %h actual %h",
                                 $time, want.value, o_time_value);
                    end
                    if (o_index_valid !== want.ok) begin
                        errors++;
                        $display("%0t: index_valid expected %b actual %b",
                                 $time, want.ok, o_index_valid);
                    end
                    if (want.ok && want.value != 0) spans_seen++;
                end
                stall_left = fast_out ? 0 : $urandom_range(0, 14);
                if ($urandom_range(0, 63) == 0) fast_out = !fast_out;
            end
            if (stall_left > 0) begin
                i_out_ready <= 1'b0;
                stall_left--;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("%0t: timeout with %0d results outstanding", $time, pending_q.size());
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial begin
        bit drained;
        bank_now = '0;
        for (int w = 0; w < NumTimers; w++) clear_watch(w);
        drained = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int r = 0; r < PlanRows; r++) begin
            send_beat(plan[r].kind, plan[r].idx, plan[r].fixed, plan[r].value, plan[r].ok);
        end

        while (beats_in < PlanRows + RandomBeats) begin
            if (!drained && beats_in >= PlanRows + RandomBeats / 2) begin
                drained = 1'b1;
                i_in_valid <= 1'b0;
                @(posedge i_clk);
                while (pending_q.size() != 0) @(posedge i_clk);
            end
            if ($urandom_range(0, 9) < 6) timing_run();
            else send_random(pick_kind(), IndexW'($urandom_range(0, 15)));
        end
        i_in_valid <= 1'b0;

        @(posedge i_clk);
        while (pending_q.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);

        $display("%0d beats in, %0d results checked, %0d nonzero times returned",
                 beats_in, results_seen, spans_seen);
        $display("final time count %0d, %0d mismatches", bank_now, errors);
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* files.f */
rtl/core/swb_pkg.sv
rtl/core/stopwatch_bank_core.sv
test/testbench.sv
